/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the core modules.
// Simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/lups_pkg.sv */
package lups_pkg;

   localparam int SLOT_COUNT     = 10;
   localparam int USE_COUNT_BITS = 31;
   localparam int SLOT_IDX_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Request modes.
   localparam logic [1:0] MODE_CANDIDATE     = 2'd0;
   localparam logic [1:0] MODE_DEVICE_DOWN   = 2'd1;
   localparam logic [1:0] MODE_ROUTE_REMOVED = 2'd2;

   // Selection sources reported with each result.
   localparam logic [1:0] SRC_NEW_OR_ZERO    = 2'd0;
   localparam logic [1:0] SRC_LEAST_USED     = 2'd1;
   localparam logic [1:0] SRC_FIRST_FALLBACK = 2'd2;
   localparam logic [1:0] SRC_HELD           = 2'd3;

   typedef logic [SLOT_IDX_BITS-1:0]  slot_idx_type;
   typedef logic [USE_COUNT_BITS-1:0] use_count_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] route_id;
      logic [15:0] device_id;
      logic        eligible;
      logic        hold_previous;
      logic        first_of_list;
      logic        last_of_list;
   } req_type;

   typedef struct packed {
      logic [15:0] selected_route;
      logic [1:0]  selection_source;
   } rsp_type;

   // What the slot table reports about the device of the current request.
   typedef struct packed {
      logic          hit;
      slot_idx_type  hit_slot;
      use_count_type hit_count;
      logic          free_avail;
      slot_idx_type  free_slot;
   } slot_lookup_type;

   // Updates the selector asks the slot table to make.
   typedef struct packed {
      logic         alloc_en;
      slot_idx_type alloc_slot;
      logic         free_en;
      slot_idx_type free_slot;
      logic         bump_en;
      slot_idx_type bump_slot;
   } slot_cmd_type;

endpackage

/* rtl/core/lups_slot_table.sv */
`include "assert_macros.svh"

module lups_slot_table import lups_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [15:0]     lookup_device,
   input  slot_cmd_type    cmd,
   output slot_lookup_type lookup
);

   logic [SLOT_COUNT-1:0] slot_used_ff;
   logic [SLOT_COUNT-1:0] slot_used_in;
   logic [15:0]           slot_device_ff [SLOT_COUNT];
   logic [15:0]           slot_device_in [SLOT_COUNT];
   use_count_type         slot_count_ff  [SLOT_COUNT];
   use_count_type         slot_count_in  [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] match;
   logic [SLOT_COUNT-1:0] alloc_vec;
   logic [SLOT_COUNT-1:0] free_vec;
   logic [SLOT_COUNT-1:0] bump_vec;
   logic                  overflow;

   // Parallel compare of every slot against the requested device.
   always_comb begin
      lookup     = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match[i] = slot_used_ff[i] && (slot_device_ff[i] == lookup_device);
         if (match[i]) begin
            lookup.hit_slot  = SLOT_IDX_BITS'(i);
            lookup.hit_count = lookup.hit_count | slot_count_ff[i];
         end
      end
      lookup.hit = |match;
      // Lowest free slot wins, so scan downward and let the last write stand.
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            lookup.free_slot = SLOT_IDX_BITS'(i);
         end
      end
      lookup.free_avail = ~&slot_used_ff;
   end

   always_comb begin
      overflow = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         alloc_vec[i] = cmd.alloc_en && (cmd.alloc_slot == SLOT_IDX_BITS'(i));
         free_vec[i]  = cmd.free_en  && (cmd.free_slot  == SLOT_IDX_BITS'(i));
         bump_vec[i]  = cmd.bump_en  && (cmd.bump_slot  == SLOT_IDX_BITS'(i));
         // A freshly allocated slot starts from zero and cannot overflow.
         if (bump_vec[i] && !alloc_vec[i] && (&slot_count_ff[i])) begin
            overflow = 1'b1;
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_used_in[i]   = slot_used_ff[i];
         slot_device_in[i] = slot_device_ff[i];
         if (free_vec[i]) begin
            slot_used_in[i]   = 1'b0;
            slot_device_in[i] = '0;
         end else if (alloc_vec[i]) begin
            slot_used_in[i]   = 1'b1;
            slot_device_in[i] = lookup_device;
         end
         if (overflow || free_vec[i]) begin
            slot_count_in[i] = '0;
         end else begin
            slot_count_in[i] = (alloc_vec[i] ? '0 : slot_count_ff[i])
                             + USE_COUNT_BITS'(bump_vec[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_count_ff[i] <= '0;
         end
      end else begin
         slot_used_ff <= slot_used_in;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_count_ff[i] <= slot_count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_device_ff[i] <= slot_device_in[i];
      end
   end

   `ASSERT_IMPLIES(a_single_match, clock, reset, 1'b1, $countones(match) <= 1)
   `ASSERT_IMPLIES(a_alloc_free_slot, clock, reset, cmd.alloc_en, !cmd.free_en && !lookup.hit)
   `ASSERT_NEXT(a_overflow_clears, clock, reset, overflow, slot_count_ff[0] == '0)

endmodule

/* rtl/core/lups_select.sv */
`include "assert_macros.svh"

module lups_select import lups_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  req_type         item,
   input  slot_lookup_type lookup,
   output slot_cmd_type    cmd,
   output logic            out_valid,
   output rsp_type         out_data
);

   logic [15:0]   last_route_ff,       last_route_in;
   logic          last_valid_ff,       last_valid_in;
   logic [15:0]   list_first_route_ff, list_first_route_in;
   use_count_type running_min_ff,      running_min_in;
   slot_idx_type  min_slot_ff,         min_slot_in;
   logic [15:0]   min_route_ff,        min_route_in;
   logic          min_found_ff,        min_found_in;
   logic [15:0]   winner_route_ff,     winner_route_in;
   logic          winner_found_ff,     winner_found_in;
   logic          holding_ff,          holding_in;

   logic          cand;
   logic          holding_eff;
   logic          take;
   logic          skip;
   logic          fresh;
   logic          win;
   logic          upd_min;
   slot_idx_type  cand_slot;

   always_comb begin
      cmd                 = '0;
      out_valid           = 1'b0;
      out_data            = '0;
      last_route_in       = last_route_ff;
      last_valid_in       = last_valid_ff;
      list_first_route_in = list_first_route_ff;
      running_min_in      = running_min_ff;
      min_slot_in         = min_slot_ff;
      min_route_in        = min_route_ff;
      min_found_in        = min_found_ff;
      winner_route_in     = winner_route_ff;
      winner_found_in     = winner_found_ff;
      holding_in          = holding_ff;
      holding_eff         = holding_ff;
      take                = 1'b0;
      skip                = 1'b0;
      fresh               = 1'b0;
      win                 = 1'b0;
      upd_min             = 1'b0;
      cand_slot           = lookup.hit ? lookup.hit_slot : lookup.free_slot;
      cand                = item_valid && (item.mode == MODE_CANDIDATE);

      if (item_valid && (item.mode == MODE_DEVICE_DOWN)) begin
         cmd.free_en   = lookup.hit;
         cmd.free_slot = lookup.hit_slot;
      end

      if (item_valid && (item.mode == MODE_ROUTE_REMOVED)) begin
         if (last_valid_ff && (last_route_ff == item.route_id)) begin
            last_valid_in = 1'b0;
         end
      end

      if (cand) begin
         // A first mark opens a fresh list.
         if (item.first_of_list) begin
            running_min_in      = '1;
            min_slot_in         = '0;
            min_route_in        = '0;
            min_found_in        = 1'b0;
            winner_route_in     = '0;
            winner_found_in     = 1'b0;
            list_first_route_in = item.route_id;
            holding_in          = item.hold_previous && last_valid_ff;
         end
         holding_eff = holding_in;

         take  = !holding_eff && item.eligible && !winner_found_in;
         fresh = !lookup.hit && lookup.free_avail;
         skip  = !lookup.hit && !lookup.free_avail;
         win   = take && !skip
              && (fresh || (min_found_in && (running_min_in == '0)));
         upd_min = take && !skip && !win
                && (!min_found_in || (lookup.hit_count < running_min_in));

         cmd.alloc_en   = take && fresh;
         cmd.alloc_slot = cand_slot;

         if (win) begin
            winner_route_in = item.route_id;
            winner_found_in = 1'b1;
            cmd.bump_en     = 1'b1;
            cmd.bump_slot   = cand_slot;
         end
         if (upd_min) begin
            running_min_in = lookup.hit_count;
            min_slot_in    = cand_slot;
            min_route_in   = item.route_id;
            min_found_in   = 1'b1;
         end

         if (item.last_of_list) begin
            out_valid = 1'b1;
            if (holding_eff) begin
               out_data.selected_route   = last_route_ff;
               out_data.selection_source = SRC_HELD;
            end else begin
               if (winner_found_in) begin
                  out_data.selected_route   = winner_route_in;
                  out_data.selection_source = SRC_NEW_OR_ZERO;
               end else if (min_found_in) begin
                  cmd.bump_en               = 1'b1;
                  cmd.bump_slot             = min_slot_in;
                  out_data.selected_route   = min_route_in;
                  out_data.selection_source = SRC_LEAST_USED;
               end else begin
                  out_data.selected_route   = list_first_route_in;
                  out_data.selection_source = SRC_FIRST_FALLBACK;
               end
               last_route_in = out_data.selected_route;
               last_valid_in = 1'b1;
            end
            running_min_in  = '1;
            min_slot_in     = '0;
            min_route_in    = '0;
            min_found_in    = 1'b0;
            winner_route_in = '0;
            winner_found_in = 1'b0;
            holding_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_route_ff       <= '0;
         last_valid_ff       <= 1'b0;
         list_first_route_ff <= '0;
         running_min_ff      <= '1;
         min_slot_ff         <= '0;
         min_route_ff        <= '0;
         min_found_ff        <= 1'b0;
         winner_route_ff     <= '0;
         winner_found_ff     <= 1'b0;
         holding_ff          <= 1'b0;
      end else begin
         last_route_ff       <= last_route_in;
         last_valid_ff       <= last_valid_in;
         list_first_route_ff <= list_first_route_in;
         running_min_ff      <= running_min_in;
         min_slot_ff         <= min_slot_in;
         min_route_ff        <= min_route_in;
         min_found_ff        <= min_found_in;
         winner_route_ff     <= winner_route_in;
         winner_found_ff     <= winner_found_in;
         holding_ff          <= holding_in;
      end
   end

   `ASSERT_IMPLIES(a_hold_no_winner, clock, reset, holding_ff, !winner_found_ff && !min_found_ff)
   `ASSERT_IMPLIES(a_bump_not_held, clock, reset, cmd.bump_en, !holding_eff && !cmd.free_en)
   `ASSERT_NEXT(a_sel_recorded, clock, reset, out_valid && (out_data.selection_source != SRC_HELD), last_valid_ff)

endmodule

/* rtl/core/least_used_path_selector_core.sv */
// Channel   | Ports                       | Handshake
// ----------+-----------------------------+--------------------------------------
// request   | start, busy, req_payload    | taken on a rising edge with start=1, busy=0
// result    | rsp_valid, rsp_payload      | one-cycle strobe, receiver cannot stall
//
// Each request is captured in an input register, the slot table lookup and
// selection run in the following cycle, and the result register presents the
// response on the cycle after that. A new request can be accepted in every cycle,
// so busy is always low and the sustained rate is one request per cycle; the slot
// table compare is the long path.
// Reset is synchronous and active high; it empties the slot table and the list
// state. Results cannot be held off, so there is no backpressure anywhere.
module least_used_path_selector_core import lups_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   // Input register stage.
   logic    item_valid_ff, item_valid_in;
   req_type item_ff,       item_in;

   // Result register stage.
   logic    rsp_valid_ff,  rsp_valid_in;
   rsp_type rsp_data_ff,   rsp_data_in;

   slot_lookup_type lookup;
   slot_cmd_type    cmd;
   logic            sel_valid;
   rsp_type         sel_data;

   // The core never pushes back, so busy is tied low.
   assign busy = 1'b0;

   assign item_valid_in = start && !busy;
   assign item_in       = req_payload;

   // The slot table answers for the device of the registered request and applies
   // the allocation, release and count updates that the selector decides on.
   lups_slot_table u_slot_table (
      .clock         (clock),
      .reset         (reset),
      .lookup_device (item_ff.device_id),
      .cmd           (cmd),
      .lookup        (lookup)
   );

   // The selector keeps the per-list running minimum, the winner and the
   // previously chosen route, and forms the response on the last candidate.
   lups_select u_select (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .lookup     (lookup),
      .cmd        (cmd),
      .out_valid  (sel_valid),
      .out_data   (sel_data)
   );

   assign rsp_valid_in = sel_valid;
   assign rsp_data_in  = sel_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (item_valid_in) begin
         item_ff <= item_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* dv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lups_pkg::*;

   // The package names the three defined modes; the fourth encoding is
   // exercised as well, and the block must drop it without a result.
   localparam logic [1:0] MODE_UNKNOWN = 2'd3;

   // Requests after which the run stops sending, and the number of quiet
   // cycles (nothing accepted in either direction) that counts as a hang.
   localparam int REQUEST_TARGET = 650;
   localparam int QUIET_LIMIT    = 1000;

   // Tracks the slot table and list state of the selector, works out the
   // selection each request should cause, and checks the results in order.
   class path_selection_board;
      logic          slot_used[SLOT_COUNT];
      logic [15:0]   slot_device[SLOT_COUNT];
      use_count_type slot_count[SLOT_COUNT];
      logic [15:0]   last_route;
      logic          last_valid;
      logic [15:0]   list_first_route;
      logic [31:0]   running_min;
      int            min_slot;
      logic [15:0]   min_route;
      logic          min_found;
      logic [15:0]   winner_route;
      logic          winner_found;
      logic          holding;
      rsp_type       pending_selections[$];
      int            failures;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_used[i]   = 1'b0;
            slot_device[i] = '0;
            slot_count[i]  = '0;
         end
         last_route       = '0;
         last_valid       = 1'b0;
         list_first_route = '0;
         failures         = 0;
         clear_list();
      endfunction

      function void clear_list();
         running_min  = '1;
         min_slot     = 0;
         min_route    = '0;
         min_found    = 1'b0;
         winner_route = '0;
         winner_found = 1'b0;
         holding      = 1'b0;
      endfunction

      function int find_slot(logic [15:0] dev);
         int s;
         s = -1;
         for (int i = 0; i < SLOT_COUNT; i++)
            if (s < 0 && slot_used[i] && slot_device[i] == dev)
               s = i;
         return s;
      endfunction

      // A count at its maximum wraps the whole table back to zero.
      function void bump_use(int s);
         if (slot_count[s] == '1) begin
            for (int i = 0; i < SLOT_COUNT; i++)
               slot_count[i] = '0;
         end else begin
            slot_count[s] = slot_count[s] + USE_COUNT_BITS'(1);
         end
      endfunction

      function void note_request(req_type r);
         int      s;
         logic    fresh;
         rsp_type sel;
         case (r.mode)
            MODE_DEVICE_DOWN: begin
               s = find_slot(r.device_id);
               if (s >= 0) begin
                  slot_used[s]   = 1'b0;
                  slot_device[s] = '0;
                  slot_count[s]  = '0;
               end
            end
            MODE_ROUTE_REMOVED: begin
               if (last_valid && last_route == r.route_id)
                  last_valid = 1'b0;
            end
            MODE_CANDIDATE: begin
               if (r.first_of_list) begin
                  clear_list();
                  list_first_route = r.route_id;
                  holding = r.hold_previous && last_valid;
               end
               if (!holding && r.eligible && !winner_found) begin
                  fresh = 1'b0;
                  s = find_slot(r.device_id);
                  if (s < 0) begin
                     for (int i = 0; i < SLOT_COUNT; i++)
                        if (s < 0 && !slot_used[i])
                           s = i;
                     if (s >= 0) begin
                        slot_used[s]   = 1'b1;
                        slot_device[s] = r.device_id;
                        slot_count[s]  = '0;
                        fresh = 1'b1;
                     end
                  end
                  // With no slot to be had the candidate is simply skipped.
                  if (s >= 0) begin
                     if (fresh || (min_found && running_min == 0)) begin
                        bump_use(s);
                        winner_route = r.route_id;
                        winner_found = 1'b1;
                     end else if (!min_found || slot_count[s] < running_min) begin
                        running_min = slot_count[s];
                        min_slot    = s;
                        min_route   = r.route_id;
                        min_found   = 1'b1;
                     end
                  end
               end
               if (r.last_of_list) begin
                  if (holding) begin
                     sel.selected_route   = last_route;
                     sel.selection_source = SRC_HELD;
                  end else begin
                     if (winner_found) begin
                        sel.selected_route   = winner_route;
                        sel.selection_source = SRC_NEW_OR_ZERO;
                     end else if (min_found) begin
                        bump_use(min_slot);
                        sel.selected_route   = min_route;
                        sel.selection_source = SRC_LEAST_USED;
                     end else begin
                        sel.selected_route   = list_first_route;
                        sel.selection_source = SRC_FIRST_FALLBACK;
                     end
                     last_route = sel.selected_route;
                     last_valid = 1'b1;
                  end
                  clear_list();
                  pending_selections.push_back(sel);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_selections.size() == 0) begin
            $error("unexpected result: route %0h source %0d",
                   got.selected_route, got.selection_source);
            failures++;
         end else begin
            want = pending_selections.pop_front();
            if (got.selected_route !== want.selected_route) begin
               $error("selected_route: expected %0h, got %0h",
                      want.selected_route, got.selected_route);
               failures++;
            end
            if (got.selection_source !== want.selection_source) begin
               $error("selection_source: expected %0d, got %0d",
                      want.selection_source, got.selection_source);
               failures++;
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   path_selection_board sb = new();

   int          requests_sent = 0;
   int          quiet_cycles  = 0;
   logic [15:0] device_pool[16];

   least_used_path_selector_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Results are strobes that cannot be stalled, so every strobe seen after
   // reset is checked against the oldest expected selection.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_payload);
   end

   // A hang shows up as a long run of cycles in which neither a request nor
   // a result is accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(logic [1:0] mode, logic [15:0] route,
                                        logic [15:0] dev, logic elig, logic hold,
                                        logic first, logic last);
      req_type r;
      r.mode          = mode;
      r.route_id      = route;
      r.device_id     = dev;
      r.eligible      = elig;
      r.hold_previous = hold;
      r.first_of_list = first;
      r.last_of_list  = last;
      return r;
   endfunction

   // Most devices come from a small pool, larger than the slot table, so
   // that counts build up, the table fills and slots are reused; the rest
   // are arbitrary.
   function automatic logic [15:0] pick_device();
      if ($urandom_range(99) < 88)
         return device_pool[$urandom_range(15)];
      return 16'($urandom);
   endfunction

   // The sender idles in phases of 60 requests: none, heavy, none, light.
   function automatic int idle_percent();
      case ((requests_sent / 60) % 4)
         1:       return 69;
         3:       return 7;
         default: return 0;
      endcase
   endfunction

   // Presents one request, after idle cycles drawn one cycle at a time, and
   // holds it until the block takes it. The payload carries junk while start
   // is low.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < idle_percent()) begin
         start       <= 1'b0;
         req_payload <= req_type'({$urandom, $urandom});
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      requests_sent++;
   endtask

   // Sends one candidate list. The marks can be left off to build broken
   // lists, and a device can now and then go down in the middle of a list.
   task automatic send_list(input int len, input logic with_first, input logic with_last);
      logic hold;
      hold = $urandom_range(99) < 25;
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(99) < 5)
            send_request(make_req(MODE_DEVICE_DOWN, 16'($urandom), pick_device(),
                                  1'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom)));
         send_request(make_req(MODE_CANDIDATE, 16'($urandom), pick_device(),
                               $urandom_range(99) < 80,
                               (i == 0) ? hold : 1'($urandom),
                               (i == 0) && with_first,
                               (i == len - 1) && with_last));
      end
   endtask

   initial begin
      int   pick;
      logic first_mark;

      device_pool[0] = 16'h0000;
      device_pool[1] = 16'hFFFF;
      for (int i = 2; i < 16; i++)
         device_pool[i] = 16'($urandom);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A candidate with no first mark right after reset continues the list
      // that reset left behind; its device is new, so it wins.
      send_request(make_req(MODE_CANDIDATE, 16'h1234, 16'd5, 1'b1, 1'b0, 1'b0, 1'b1));
      send_request(make_req(MODE_CANDIDATE, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b1));
      // The same device again has a nonzero count, so the least used wins.
      send_request(make_req(MODE_CANDIDATE, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b1));
      // A new device wins at once and the rest of its list is ignored.
      send_request(make_req(MODE_CANDIDATE, 16'd10, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0));
      send_request(make_req(MODE_CANDIDATE, 16'd11, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
      send_request(make_req(MODE_CANDIDATE, 16'd12, 16'd5, 1'b1, 1'b1, 1'b0, 1'b1));
      // Hold returns the previous selection.
      send_request(make_req(MODE_CANDIDATE, 16'd20, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1));
      // Nothing eligible falls back to the first route.
      send_request(make_req(MODE_CANDIDATE, 16'd30, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
      send_request(make_req(MODE_CANDIDATE, 16'd31, 16'd5, 1'b0, 1'b1, 1'b0, 1'b1));
      // Removing the selected route cancels the next hold; another route does not.
      send_request(make_req(MODE_ROUTE_REMOVED, 16'd30, 16'h0000,
                            1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(MODE_CANDIDATE, 16'd40, 16'd5, 1'b1, 1'b1, 1'b1, 1'b1));
      send_request(make_req(MODE_ROUTE_REMOVED, 16'h7777, 16'hFFFF,
                            1'b1, 1'b1, 1'b1, 1'b1));
      // The device of the recorded minimum goes down in the middle of a list.
      send_request(make_req(MODE_CANDIDATE, 16'd50, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0));
      send_request(make_req(MODE_DEVICE_DOWN, 16'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_req(MODE_CANDIDATE, 16'd51, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
      // Fill the table, then offer a device that finds no slot.
      for (int i = 0; i < 8; i++)
         send_request(make_req(MODE_CANDIDATE, 16'(100 + i), 16'(100 + i),
                               1'b1, 1'b0, 1'b1, 1'b1));
      send_request(make_req(MODE_CANDIDATE, 16'd60, 16'd200, 1'b1, 1'b0, 1'b1, 1'b1));
      // The unused mode encoding must be dropped.
      send_request(make_req(MODE_UNKNOWN, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));

      // Random part: mostly well-formed lists, with broken lists, device and
      // route events and plain noise mixed in.
      while (requests_sent < REQUEST_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_list($urandom_range(1, 5), 1'b1, 1'b1);
         end else if (pick < 78) begin
            first_mark = 1'($urandom);
            send_list($urandom_range(1, 5), first_mark, first_mark ? 1'b0 : 1'($urandom));
         end else if (pick < 87) begin
            send_request(make_req(MODE_DEVICE_DOWN, 16'($urandom), pick_device(),
                                  1'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom)));
         end else if (pick < 95) begin
            send_request(make_req(MODE_ROUTE_REMOVED,
                                  $urandom_range(1) ? sb.last_route : 16'($urandom),
                                  16'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom), 1'($urandom)));
         end else if (pick < 97) begin
            send_request(make_req(MODE_UNKNOWN, 16'($urandom), 16'($urandom),
                                  1'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom)));
         end else begin
            send_request(make_req(MODE_CANDIDATE, 16'($urandom), 16'($urandom),
                                  1'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom)));
         end
      end
      start <= 1'b0;

      // Drain the outstanding selections, then keep the clock running so that any
      // stray result from the pipeline shows.
      while (sb.pending_selections.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      if (sb.failures == 0 && sb.pending_selections.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lups_pkg.sv
rtl/core/lups_slot_table.sv
rtl/core/lups_select.sv
rtl/core/least_used_path_selector_core.sv
dv/tb.sv
